// ===== design/cribaf_pkg.sv =====
// Shared types and constants for the crib alignment filter.
// No dependencies; every module of the block imports this package.
package cribaf_pkg;

	localparam int REQ_W     = 2;
	localparam int LETTER_W  = 5;
	localparam int IDX_W     = 5;
	localparam int POS_W     = 16;
	localparam int CFG_LEN_W = 6;
	localparam int S_TDATA_W = 16;
	localparam int M_TDATA_W = 16;
	localparam int PADDR_W   = 3;
	localparam int PDATA_W   = 32;

	localparam logic [REQ_W-1:0] REQ_LOAD = 2'd0;
	localparam logic [REQ_W-1:0] REQ_TEXT = 2'd1;
	localparam logic [REQ_W-1:0] REQ_END  = 2'd2;

	// Register word index, taken from paddr[2].
	localparam logic REG_LEN_CFG    = 1'b0;
	localparam logic REG_ONLY_FIRST = 1'b1;

	typedef struct packed {
		logic                clear;
		logic                shift;
		logic                load;
		logic [LETTER_W-1:0] letter;
	} cell_ctrl_t;

	typedef struct packed {
		logic [POS_W-1:0] position;
		logic             none_found;
	} result_t;

endpackage

// ===== design/cribaf_cell.sv =====
// One cell of the alignment chain: a crib letter and the reject flag of one offset.
// Depends on cribaf_pkg.
module cribaf_cell (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cribaf_pkg::cell_ctrl_t ctrl,
	input  logic                  sel,
	input  logic                  active,
	input  logic                  flag_in,
	output logic                  flag,
	output logic                  flag_nxt
);
	import cribaf_pkg::*;

	logic [LETTER_W-1:0] crib_q;
	logic                flag_q;

	// Crib storage has no reset; it is defined once loaded.
	always_ff @(posedge clk) begin
		if (ctrl.load && sel) begin
			crib_q <= ctrl.letter;
		end
	end

	assign flag_nxt = flag_in | (crib_q == ctrl.letter);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flag_q <= 1'b0;
		end else if (ctrl.clear) begin
			flag_q <= 1'b0;
		end else if (ctrl.shift && active) begin
			flag_q <= flag_nxt;
		end
	end

	assign flag = flag_q;

endmodule

// ===== design/cribaf_outbuf.sv =====
// Two-entry output buffer: an output register backed by a skid register.
// Depends on cribaf_pkg.
module cribaf_outbuf (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  cribaf_pkg::result_t push_data,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	output cribaf_pkg::result_t out_data
);
	import cribaf_pkg::*;

	result_t out_q;
	result_t skid_q;
	logic    out_valid_q;
	logic    skid_valid_q;
	logic    pop;

	assign pop = out_valid_q & out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (pop) begin
				skid_valid_q <= 1'b0;
			end
		end else if (push) begin
			if (!out_valid_q || pop) begin
				out_valid_q <= 1'b1;
			end else begin
				skid_valid_q <= 1'b1;
			end
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (pop) begin
				out_q <= skid_q;
			end
		end else if (push) begin
			if (!out_valid_q || pop) begin
				out_q <= push_data;
			end else begin
				skid_q <= push_data;
			end
		end
	end

	// A new transfer is taken whenever the skid register is free.
	assign in_ready  = ~skid_valid_q;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

// ===== design/crib_alignment_filter.sv =====
// Top level of the crib alignment filter: register port, cell chain, output buffer.
// Depends on cribaf_pkg, cribaf_cell and cribaf_outbuf.
//
//   channel   | direction | signals                              | carries
//   ----------+-----------+--------------------------------------+-----------------------------
//   s_ stream | in        | s_tvalid s_tready s_tdata s_tuser    | crib loads, letters, ends
//   m_ stream | out       | m_tvalid m_tready m_tdata m_tuser    | positions, end-of-message
//   APB       | in/out    | psel penable pwrite paddr pwdata ... | crib length, first-only mode
//
// A new request is taken each cycle unless s_tready is low. All crib positions are
// compared in parallel in the cell row, so the rate is one letter per unstalled clock.
// A result goes into the output register, or into the skid register while that one is full.
// s_tready drops only when both the output register and the skid register hold results.
// Reset clears the reject flags, counters and buffer; crib letters keep no reset value.
module crib_alignment_filter #(
	parameter int MAX_CRIB = 32,
	parameter int MAX_TEXT = 65536
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic [cribaf_pkg::S_TDATA_W-1:0]     s_tdata,  // letter[4:0], crib_index[9:5]
	input  logic [cribaf_pkg::REQ_W-1:0]         s_tuser,  // req_type[1:0]
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output logic [cribaf_pkg::M_TDATA_W-1:0]     m_tdata,  // position[15:0]
	output logic [0:0]                           m_tuser,  // none_found[0]
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [cribaf_pkg::PADDR_W-1:0]       paddr,
	input  logic [cribaf_pkg::PDATA_W-1:0]       pwdata,
	output logic [cribaf_pkg::PDATA_W-1:0]       prdata,
	output logic                                 pready
);
	import cribaf_pkg::*;

	localparam int CW = $clog2(MAX_TEXT + 1);
	localparam int IW = (MAX_CRIB > 1) ? $clog2(MAX_CRIB) : 1;
	localparam int LW = 7;

	logic [CFG_LEN_W-1:0] len_cfg_q;
	logic                 only_first_q;
	logic [CW-1:0]        count_q;
	logic                 found_any_q;

	logic                 in_fire;
	logic                 cfg_wr;
	logic [LETTER_W-1:0]  letter;
	logic [IDX_W-1:0]     crib_index;
	logic [REQ_W-1:0]     req_type;
	logic [LW-1:0]        len;
	logic                 text_go;
	logic                 survive;
	logic                 push;
	logic [CW:0]          cnt_p1;
	logic [CW:0]          len_ext;
	cell_ctrl_t           ctrl;
	result_t              res;
	result_t              out_res;
	logic [MAX_CRIB-1:0]  flags;
	logic [MAX_CRIB-1:0]  flags_nxt;

	// Configuration registers.
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_cfg_q    <= CFG_LEN_W'(1);
			only_first_q <= 1'b0;
		end else if (cfg_wr) begin
			if (paddr[2] == REG_LEN_CFG) begin
				len_cfg_q <= pwdata[CFG_LEN_W-1:0];
			end else begin
				only_first_q <= pwdata[0];
			end
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[2] == REG_LEN_CFG) begin
			prdata[CFG_LEN_W-1:0] = len_cfg_q;
		end else begin
			prdata[0] = only_first_q;
		end
	end

	// Zero length counts as one, and lengths above the chain are clipped to it.
	always_comb begin
		if (len_cfg_q == '0) begin
			len = LW'(1);
		end else if (LW'(len_cfg_q) > LW'(MAX_CRIB)) begin
			len = LW'(MAX_CRIB);
		end else begin
			len = LW'(len_cfg_q);
		end
	end

	assign in_fire    = s_tvalid & s_tready;
	assign letter     = s_tdata[LETTER_W-1:0];
	assign crib_index = s_tdata[LETTER_W +: IDX_W];
	assign req_type   = s_tuser;

	// Letters beyond the counter limit are dropped until the end of message.
	assign text_go = in_fire && (req_type == REQ_TEXT) && (count_q < CW'(MAX_TEXT));

	assign ctrl.clear  = in_fire && (req_type == REQ_END);
	assign ctrl.shift  = text_go;
	assign ctrl.load   = in_fire && (req_type == REQ_LOAD);
	assign ctrl.letter = letter;

	for (genvar k = 0; k < MAX_CRIB; k++) begin : g_cell
		logic flag_in;
		if (k == 0) begin : g_head
			assign flag_in = 1'b0;
		end else begin : g_link
			assign flag_in = flags[k-1];
		end
		cribaf_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctrl     (ctrl),
			.sel      (LW'(crib_index) == LW'(k)),
			.active   (len > LW'(k)),
			.flag_in  (flag_in),
			.flag     (flags[k]),
			.flag_nxt (flags_nxt[k])
		);
	end

	assign cnt_p1  = (CW + 1)'(count_q) + (CW + 1)'(1);
	assign len_ext = (CW + 1)'(len);
	assign survive = text_go && (cnt_p1 >= len_ext) && !flags_nxt[IW'(len - LW'(1))];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			found_any_q <= 1'b0;
		end else if (ctrl.clear) begin
			count_q     <= '0;
			found_any_q <= 1'b0;
		end else if (text_go) begin
			count_q <= count_q + CW'(1);
			if (survive) begin
				found_any_q <= 1'b1;
			end
		end
	end

	always_comb begin
		res  = '0;
		push = 1'b0;
		if (ctrl.clear) begin
			res.none_found = ~found_any_q;
			push           = 1'b1;
		end else if (survive && !(only_first_q && found_any_q)) begin
			res.position = POS_W'(cnt_p1 - len_ext);
			push         = 1'b1;
		end
	end

	cribaf_outbuf u_outbuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (res),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (out_res)
	);

	assign m_tdata    = out_res.position;
	assign m_tuser[0] = out_res.none_found;

endmodule

// ===== design/cribaf_checker.sv =====
// Port-level checks for the crib alignment filter, bound to the top level.
// Depends on cribaf_pkg and crib_alignment_filter.
module cribaf_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             s_tvalid,
	input logic                             s_tready,
	input logic [cribaf_pkg::S_TDATA_W-1:0] s_tdata,
	input logic [cribaf_pkg::REQ_W-1:0]     s_tuser,
	input logic                             m_tvalid,
	input logic                             m_tready,
	input logic [cribaf_pkg::M_TDATA_W-1:0] m_tdata,
	input logic [0:0]                       m_tuser,
	input logic                             psel,
	input logic                             penable,
	input logic                             pwrite,
	input logic [cribaf_pkg::PADDR_W-1:0]   paddr,
	input logic [cribaf_pkg::PDATA_W-1:0]   pwdata,
	input logic [cribaf_pkg::PDATA_W-1:0]   prdata,
	input logic                             pready
);
	import cribaf_pkg::*;

	// An end-of-message transfer is always followed by m_tvalid high on the next cycle.
	a_end_result: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tuser == REQ_END) |=> m_tvalid)
		else $error("end of message produced no result");

	// The end-of-message result carries a zero position.
	a_end_zero_pos: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tdata == '0)
		else $error("none_found result with nonzero position");

	// Input back-pressure only happens with a result waiting at the output.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid)
		else $error("input stalled with an empty output");

	// A stalled result holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled result changed");

endmodule

bind crib_alignment_filter cribaf_checker u_cribaf_checker (.*);
